[hdl/mrfb_pkg.sv]
// Shared types, constants and the CRC-16 byte update for the Modbus RTU
// frame builder. No dependencies.
`default_nettype none

package mrfb_pkg;

  // CRC-16/Modbus: preset all ones, reflected polynomial
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Payload bytes at zero-based index MAX_DATA_BYTES or beyond are flagged
  localparam logic [7:0] MAX_DATA_BYTES = 8'd252;
  localparam logic [7:0] COUNT_SAT      = 8'hFF;

  // Default depth of the queue between the front and the back
  localparam int QUEUE_DEPTH_DEF = 2;

  // One classified item, as handed from the front to the back
  typedef struct packed {
    logic       hdr;       // item opens a frame: emit address and function code
    logic [7:0] addr;
    logic [7:0] func;
    logic       has_data;
    logic [7:0] data;
    logic       too_long;  // payload byte past the size limit
    logic       last;      // append the CRC after this item
  } cmd_t;

  // Byte-wise CRC update, LSB first
  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hdl/mrfb_if.sv]
// Valid/ready channel interfaces for the frame builder: item input and
// frame byte output. No dependencies.
`default_nettype none

interface mrfb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] slave_address;
  logic [7:0] function_code;
  logic [7:0] data_byte;
  logic       has_data;
  logic       last;

  modport source (output valid, slave_address, function_code, data_byte, has_data, last,
                  input ready);
  modport sink   (input valid, slave_address, function_code, data_byte, has_data, last,
                  output ready);
endinterface

interface mrfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       end_of_frame;
  logic       too_long;

  modport source (output valid, frame_byte, end_of_frame, too_long, input ready);
  modport sink   (input valid, frame_byte, end_of_frame, too_long, output ready);
endinterface

`default_nettype wire

[hdl/mrfb_front.sv]
// Front end: accepts input words, tracks frame and payload count, and
// classifies each word into a queue entry. Uses mrfb_pkg and mrfb_in_if.
`default_nettype none

module mrfb_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  mrfb_in_if.sink            in_ch,
  input  wire logic          q_full,
  output      logic          push,
  output      mrfb_pkg::cmd_t push_cmd
);

  logic       in_frame_r, in_frame_nxt;
  logic [7:0] count_r, count_nxt;
  logic [7:0] count_cur;
  logic       accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // count seen by this word: a new frame starts from zero
  assign count_cur = in_frame_r ? count_r : 8'd0;

  // classification; an empty middle word yields nothing and is dropped
  always_comb begin
    push_cmd.hdr      = !in_frame_r;
    push_cmd.addr     = in_ch.slave_address;
    push_cmd.func     = in_ch.function_code;
    push_cmd.has_data = in_ch.has_data;
    push_cmd.data     = in_ch.data_byte;
    push_cmd.too_long = in_ch.has_data && (count_cur >= mrfb_pkg::MAX_DATA_BYTES);
    push_cmd.last     = in_ch.last;
    push = accept && (!in_frame_r || in_ch.has_data || in_ch.last);
  end

  // frame state
  always_comb begin
    in_frame_nxt = in_frame_r;
    count_nxt    = count_r;
    if (accept) begin
      if (in_ch.last) begin
        in_frame_nxt = 1'b0;
        count_nxt    = 8'd0;
      end else begin
        in_frame_nxt = 1'b1;
        if (in_ch.has_data && (count_cur != mrfb_pkg::COUNT_SAT)) begin
          count_nxt = count_cur + 8'd1;
        end else begin
          count_nxt = count_cur;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      count_r    <= 8'd0;
    end else begin
      in_frame_r <= in_frame_nxt;
      count_r    <= count_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/mrfb_queue.sv]
// Short FIFO of classified entries between front and back.
// Uses mrfb_pkg.
`default_nettype none

module mrfb_queue #(
  parameter int DEPTH = mrfb_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire mrfb_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output      logic           full,
  output      logic           not_empty,
  output      mrfb_pkg::cmd_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  mrfb_pkg::cmd_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // pointers wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

[hdl/mrfb_back.sv]
// Back end: byte sequencer that emits header, payload and CRC bytes into a
// registered output, one per unstalled cycle. Uses mrfb_pkg and mrfb_out_if.
`default_nettype none

module mrfb_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_not_empty,
  input  wire mrfb_pkg::cmd_t q_head,
  output      logic           pop,
  mrfb_out_if.source          out_ch
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_ADDR   = 6'b000010,
    ST_FUNC   = 6'b000100,
    ST_DATA   = 6'b001000,
    ST_CRC_LO = 6'b010000,
    ST_CRC_HI = 6'b100000
  } st_t;

  st_t            st_r, st_nxt, st_cont, st_head;
  mrfb_pkg::cmd_t cmd_r, cmd_nxt;
  logic [15:0]    crc_r, crc_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     byte_r, byte_nxt;
  logic           eof_r, eof_nxt;
  logic           tl_r, tl_nxt;
  logic           can_emit, emit, done;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.frame_byte   = byte_r;
  assign out_ch.end_of_frame = eof_r;
  assign out_ch.too_long     = tl_r;

  assign can_emit = !out_valid_r || out_ch.ready;
  assign emit     = can_emit && (st_r != ST_IDLE);

  // first byte of the entry at the queue head
  always_comb begin
    if (q_head.hdr) begin
      st_head = ST_ADDR;
    end else if (q_head.has_data) begin
      st_head = ST_DATA;
    end else begin
      st_head = ST_CRC_LO;
    end
  end

  // byte to emit and the step after it within the current entry
  always_comb begin
    byte_nxt = byte_r;
    eof_nxt  = 1'b0;
    tl_nxt   = 1'b0;
    crc_nxt  = crc_r;
    st_cont  = ST_IDLE;
    unique case (st_r)
      ST_IDLE: begin
        eof_nxt = eof_r;
        tl_nxt  = tl_r;
      end
      ST_ADDR: begin
        byte_nxt = cmd_r.addr;
        crc_nxt  = mrfb_pkg::crc_add(mrfb_pkg::CRC_INIT, cmd_r.addr);
        st_cont  = ST_FUNC;
      end
      ST_FUNC: begin
        byte_nxt = cmd_r.func;
        crc_nxt  = mrfb_pkg::crc_add(crc_r, cmd_r.func);
        st_cont  = cmd_r.has_data ? ST_DATA : (cmd_r.last ? ST_CRC_LO : ST_IDLE);
      end
      ST_DATA: begin
        byte_nxt = cmd_r.data;
        tl_nxt   = cmd_r.too_long;
        crc_nxt  = mrfb_pkg::crc_add(crc_r, cmd_r.data);
        st_cont  = cmd_r.last ? ST_CRC_LO : ST_IDLE;
      end
      ST_CRC_LO: begin
        byte_nxt = crc_r[7:0];
        st_cont  = ST_CRC_HI;
      end
      ST_CRC_HI: begin
        byte_nxt = crc_r[15:8];
        eof_nxt  = 1'b1;
      end
      default: begin
        st_cont = ST_IDLE;
      end
    endcase
  end

  // sequencing: take the next entry when idle or on the entry's last byte
  always_comb begin
    done          = (st_r == ST_IDLE) || (emit && (st_cont == ST_IDLE));
    pop           = q_not_empty && done;
    st_nxt        = st_r;
    cmd_nxt       = cmd_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      st_nxt        = st_cont;
    end
    if (pop) begin
      st_nxt  = st_head;
      cmd_nxt = q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    if (emit) begin
      crc_r  <= crc_nxt;
      byte_r <= byte_nxt;
      eof_r  <= eof_nxt;
      tl_r   <= tl_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/modbus_rtu_frame_builder.sv]
// Modbus RTU frame builder, top level: front end, entry queue and byte
// sequencer. Uses mrfb_pkg, mrfb_if, mrfb_front, mrfb_queue and mrfb_back.
//
// Usage
//   in_ch  : one word per handshake. The first word of a frame carries the
//            slave address and function code; any word may carry one payload
//            byte (has_data); the word with last set closes the frame.
//   out_ch : the frame on the wire, one byte per handshake: address, function
//            code, payload bytes, CRC low, CRC high (end_of_frame set).
//            too_long marks payload bytes at index MAX_DATA_BYTES or beyond.
// Timing
//   A word yields 0 to 5 bytes; the sequencer emits one byte per cycle while
//   out_ch is not stalled, and the output port is the limit. An empty middle
//   word is dropped at the input and yields no output byte. Input words are
//   taken one per cycle while the queue (QUEUE_DEPTH entries) has room. The
//   first byte of a word passes through the queue, the sequencer state and
//   the output register before it appears on out_ch.
// Reset and stalls
//   rst_n is synchronous, active low: queue empty, no frame open, out_ch
//   idle. A stall on out_ch holds the output byte; the sequencer stops, the
//   queue fills and then in_ch.ready drops.
`default_nettype none

module modbus_rtu_frame_builder #(
  parameter int QUEUE_DEPTH = mrfb_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  mrfb_in_if.sink     in_ch,
  mrfb_out_if.source  out_ch
);

  logic           push;
  mrfb_pkg::cmd_t push_cmd;
  logic           q_full;
  logic           q_not_empty;
  mrfb_pkg::cmd_t q_head;
  logic           pop;

  mrfb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  mrfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  mrfb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

[hdl/mrfb_checker.sv]
// Port-level checks for the frame builder, bound to the top level.
// Uses mrfb_pkg.
`default_nettype none

module mrfb_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] frame_byte,
  input wire logic       end_of_frame,
  input wire logic       too_long
);

  // bytes delivered since the start of the current frame, saturating
  logic [8:0] nbytes_r, nbytes_nxt;
  logic       out_acc;

  assign out_acc = out_valid && out_ready;

  always_comb begin
    nbytes_nxt = nbytes_r;
    if (out_acc) begin
      if (end_of_frame) begin
        nbytes_nxt = 9'd0;
      end else if (nbytes_r != 9'h1FF) begin
        nbytes_nxt = nbytes_r + 9'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nbytes_r <= 9'd0;
    end else begin
      nbytes_r <= nbytes_nxt;
    end
  end

  // output is idle right after reset
  a_reset_idle: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("output word valid straight after reset");

  // a stalled output word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(frame_byte)
      && $stable(end_of_frame) && $stable(too_long))
    else $error("stalled output word changed");

  // a frame holds at least address, function code and CRC low before its end
  a_frame_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && end_of_frame |-> nbytes_r >= 9'd3)
    else $error("end of frame too early");

  // oversize flag only past header plus the payload limit
  a_too_long_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && too_long |-> nbytes_r >= ({1'b0, mrfb_pkg::MAX_DATA_BYTES} + 9'd2))
    else $error("too_long flagged within the payload limit");

  // a byte is never both the last of a frame and an oversize payload byte
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(end_of_frame && too_long))
    else $error("end_of_frame and too_long together");

endmodule

bind modbus_rtu_frame_builder mrfb_checker u_mrfb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .frame_byte   (out_ch.frame_byte),
  .end_of_frame (out_ch.end_of_frame),
  .too_long     (out_ch.too_long)
);

`default_nettype wire
